[hdl/gpq_pkg.sv]
// Shared types and constants for the gamepad input qualifier.
`timescale 1ns / 1ps

package gpq_pkg;

  localparam int unsigned NUM_BUTTONS = 16;
  localparam int unsigned NUM_STICK   = 8;
  localparam int unsigned NUM_TRIG    = 2;
  localparam int unsigned NUM_HOLD    = NUM_BUTTONS + NUM_STICK;
  localparam int unsigned NUM_ALL     = NUM_HOLD + NUM_TRIG;

  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned PULL_W  = 8;
  localparam int unsigned QIDX_W  = 5;
  localparam int unsigned QTIME_W = 16;
  localparam int unsigned FIRST_W = 6;

  // Active-vector bit positions
  localparam int unsigned IDX_L_UP    = NUM_BUTTONS + 0;
  localparam int unsigned IDX_L_DOWN  = NUM_BUTTONS + 1;
  localparam int unsigned IDX_L_RIGHT = NUM_BUTTONS + 2;
  localparam int unsigned IDX_L_LEFT  = NUM_BUTTONS + 3;
  localparam int unsigned IDX_R_UP    = NUM_BUTTONS + 4;
  localparam int unsigned IDX_R_DOWN  = NUM_BUTTONS + 5;
  localparam int unsigned IDX_R_RIGHT = NUM_BUTTONS + 6;
  localparam int unsigned IDX_R_LEFT  = NUM_BUTTONS + 7;
  localparam int unsigned IDX_L_TRIG  = NUM_HOLD + 0;
  localparam int unsigned IDX_R_TRIG  = NUM_HOLD + 1;

  localparam logic [FIRST_W-1:0] FIRST_NONE = '1;

  localparam logic [SCALE_W-1:0] FULL_SCALE_RST = 16'd32767;
  localparam logic [PULL_W-1:0]  TRIG_THR_RST   = 8'd127;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SCALE_X   = 2'd0,
    CFG_FULL_SCALE_Y   = 2'd1,
    CFG_TRIG_THRESHOLD = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUAL,
    ST_QUERY,
    ST_DIV,
    ST_DONE
  } state_e;

  // First member is the most significant: button_bits lands in the lowest bits
  typedef struct packed {
    logic [QTIME_W-1:0]       query_period;
    logic [QTIME_W-1:0]       query_delay;
    logic [QIDX_W-1:0]        query_index;
    logic [PULL_W-1:0]        right_pull;
    logic [PULL_W-1:0]        left_pull;
    logic signed [AXIS_W-1:0] right_y;
    logic signed [AXIS_W-1:0] right_x;
    logic signed [AXIS_W-1:0] left_y;
    logic signed [AXIS_W-1:0] left_x;
    logic [NUM_BUTTONS-1:0]   button_bits;
  } frame_t;

  typedef struct packed {
    logic                      repeat_fire;
    logic signed [FIRST_W-1:0] first_active;
    logic [NUM_ALL-1:0]        release_edges;
    logic [NUM_ALL-1:0]        press_edges;
    logic [NUM_ALL-1:0]        held_bits;
  } result_t;

  localparam int unsigned FRAME_W     = $bits(frame_t);
  localparam int unsigned RESULT_W    = $bits(result_t);
  localparam int unsigned IN_TDATA_W  = ((FRAME_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

[hdl/gpq_axis.sv]
// Direction decode for one stick axis against its full-scale register.
`timescale 1ns / 1ps

module gpq_axis (
  input  logic signed [gpq_pkg::AXIS_W-1:0]  axis_i,
  input  logic        [gpq_pkg::SCALE_W-1:0] full_scale_i,
  output logic                               pos_o,
  output logic                               neg_o
);

  localparam int unsigned CW = gpq_pkg::AXIS_W + 2;

  logic signed [CW-1:0] twice;
  logic signed [CW-1:0] scale;

  // 2*axis vs +/- full scale: exact form of axis/full > 0.5
  assign twice = {axis_i[gpq_pkg::AXIS_W-1], axis_i, 1'b0};
  assign scale = $signed({2'b00, full_scale_i});
  assign pos_o = twice > scale;
  assign neg_o = twice < -scale;

endmodule

[hdl/gpq_lane.sv]
// Saturating hold counter for one button or stick direction.
`timescale 1ns / 1ps

module gpq_lane #(
  parameter int unsigned HOLD_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  active_i,
  output logic [HOLD_WIDTH-1:0] hold_o
);

  logic [HOLD_WIDTH-1:0] hold_q;
  logic [HOLD_WIDTH-1:0] hold_d;

  always_comb begin
    hold_d = hold_q;
    if (step_i) begin
      if (!active_i) begin
        hold_d = '0;
      end else if (hold_q != '1) begin
        hold_d = hold_q + HOLD_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else begin
      hold_q <= hold_d;
    end
  end

  assign hold_o = hold_q;

endmodule

[hdl/gpq_rem.sv]
// Restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps

module gpq_rem #(
  parameter int unsigned DW = 16,
  parameter int unsigned VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd_q, dvd_d;
  logic [VW-1:0]    div_q, div_d;
  logic [VW-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [VW:0]      trial;

  assign trial = {rem_q, dvd_q[DW-1]};

  always_comb begin
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= {1'b0, div_q}) begin
        rem_d = VW'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[VW-1:0];
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[hdl/gamepad_input_qualifier_top.sv]
// Top level of the gamepad input qualifier: lanes, merge stage and repeat query.
`timescale 1ns / 1ps
//
// One poll frame enters on the s_axis channel; one result leaves on m_axis.
// Configuration (full scales, trigger threshold) is written on the cfg
// channel by register index; the user writes it only while no frame is in
// flight, which the block itself does not enforce. cfg_ready_o is always
// high and indexes beyond the register list are dropped. From accept to
// result valid a frame passes these steps: qualify all 26 inputs and step
// the 24 hold counters in parallel lanes, pick the queried counter, run the
// bit-serial remainder unit (only when the repeat branch needs it; otherwise
// it is skipped), then load the output register. One frame is worked at a
// time: the next frame is accepted only in idle, after the last one has
// been loaded into the output register.
// The result sits in an output register: the next frame is taken while it
// waits, and a stalled receiver only holds the finished frame in its last
// step. Reset clears the previous-frame flags and the hold counters and loads
// the register defaults (full scale 32767, threshold 127).
//
module gamepad_input_qualifier_top #(
  parameter int unsigned HOLD_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // button_bits, left_x, left_y, right_x, right_y, left_pull, right_pull,
  // query_index, query_delay, query_period (lowest bit up)
  input  logic [gpq_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // held_bits, press_edges, release_edges, first_active, repeat_fire
  output logic [gpq_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [gpq_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [gpq_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned CMP_W = (HOLD_WIDTH > gpq_pkg::QTIME_W) ?
                                  HOLD_WIDTH : gpq_pkg::QTIME_W;

  gpq_pkg::state_e state_q, state_d;

  logic [gpq_pkg::SCALE_W-1:0] full_scale_x_q;
  logic [gpq_pkg::SCALE_W-1:0] full_scale_y_q;
  logic [gpq_pkg::PULL_W-1:0]  trig_thr_q;

  gpq_pkg::frame_t  frame_q;
  gpq_pkg::result_t result_q;
  logic             m_valid_q, m_valid_d;

  logic [gpq_pkg::NUM_ALL-1:0] prev_q;
  logic [gpq_pkg::NUM_ALL-1:0] held_q, press_q, rel_q;
  logic [gpq_pkg::FIRST_W-1:0] first_q, first_d;
  logic                        fire_q, fire_d;

  logic [gpq_pkg::NUM_ALL-1:0] act;
  logic [gpq_pkg::NUM_STICK-1:0] stick;
  logic [HOLD_WIDTH-1:0]       hold_w [gpq_pkg::NUM_HOLD];
  logic [HOLD_WIDTH-1:0]       hold_sel;
  logic [CMP_W-1:0]            diff;
  logic                        q_valid;

  logic                        in_xfer;
  logic                        lane_step;
  logic                        load_out;
  logic                        rem_start;
  logic                        rem_done;
  logic [gpq_pkg::QTIME_W-1:0] rem_val;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_x_q <= gpq_pkg::FULL_SCALE_RST;
      full_scale_y_q <= gpq_pkg::FULL_SCALE_RST;
      trig_thr_q     <= gpq_pkg::TRIG_THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gpq_pkg::CFG_FULL_SCALE_X:   full_scale_x_q <= cfg_data_i;
        gpq_pkg::CFG_FULL_SCALE_Y:   full_scale_y_q <= cfg_data_i;
        gpq_pkg::CFG_TRIG_THRESHOLD: trig_thr_q <= cfg_data_i[gpq_pkg::PULL_W-1:0];
        default: ;
      endcase
    end
  end

  // Qualification lanes
  gpq_axis u_axis_ly (
    .axis_i(frame_q.left_y), .full_scale_i(full_scale_y_q),
    .pos_o(stick[0]), .neg_o(stick[1])
  );
  gpq_axis u_axis_lx (
    .axis_i(frame_q.left_x), .full_scale_i(full_scale_x_q),
    .pos_o(stick[2]), .neg_o(stick[3])
  );
  gpq_axis u_axis_ry (
    .axis_i(frame_q.right_y), .full_scale_i(full_scale_y_q),
    .pos_o(stick[4]), .neg_o(stick[5])
  );
  gpq_axis u_axis_rx (
    .axis_i(frame_q.right_x), .full_scale_i(full_scale_x_q),
    .pos_o(stick[6]), .neg_o(stick[7])
  );

  always_comb begin
    act = '0;
    act[gpq_pkg::NUM_BUTTONS-1:0] = frame_q.button_bits;
    act[gpq_pkg::IDX_R_LEFT:gpq_pkg::IDX_L_UP] = stick;
    act[gpq_pkg::IDX_L_TRIG] = frame_q.left_pull > trig_thr_q;
    act[gpq_pkg::IDX_R_TRIG] = frame_q.right_pull > trig_thr_q;
  end

  for (genvar g = 0; g < gpq_pkg::NUM_HOLD; g++) begin : g_lane
    gpq_lane #(
      .HOLD_WIDTH(HOLD_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (lane_step),
      .active_i(act[g]),
      .hold_o  (hold_w[g])
    );
  end

  // Merge: lowest active index
  always_comb begin
    first_d = gpq_pkg::FIRST_NONE;
    for (int i = gpq_pkg::NUM_ALL - 1; i >= 0; i--) begin
      if (act[i]) begin
        first_d = gpq_pkg::FIRST_W'(i);
      end
    end
  end

  // Repeat query against the counters as updated by this frame
  assign q_valid  = frame_q.query_index < gpq_pkg::QIDX_W'(gpq_pkg::NUM_HOLD);
  assign hold_sel = q_valid ? hold_w[frame_q.query_index] : '0;
  assign diff     = CMP_W'(hold_sel) - CMP_W'(frame_q.query_delay);

  gpq_rem #(
    .DW(HOLD_WIDTH),
    .VW(gpq_pkg::QTIME_W)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(diff[HOLD_WIDTH-1:0]),
    .divisor_i (frame_q.query_period),
    .done_o    (rem_done),
    .rem_o     (rem_val)
  );

  // Sequencer
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    lane_step     = 1'b0;
    rem_start     = 1'b0;
    load_out      = 1'b0;
    fire_d        = fire_q;
    unique case (state_q)
      gpq_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = gpq_pkg::ST_QUAL;
        end
      end
      gpq_pkg::ST_QUAL: begin
        lane_step = 1'b1;
        state_d   = gpq_pkg::ST_QUERY;
      end
      gpq_pkg::ST_QUERY: begin
        fire_d  = 1'b0;
        state_d = gpq_pkg::ST_DONE;
        if (q_valid) begin
          if (CMP_W'(hold_sel) > CMP_W'(frame_q.query_delay)) begin
            if (frame_q.query_period != '0) begin
              rem_start = 1'b1;
              state_d   = gpq_pkg::ST_DIV;
            end
          end else begin
            fire_d = hold_sel == HOLD_WIDTH'(1);
          end
        end
      end
      gpq_pkg::ST_DIV: begin
        if (rem_done) begin
          fire_d  = rem_val == '0;
          state_d = gpq_pkg::ST_DONE;
        end
      end
      gpq_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = gpq_pkg::ST_IDLE;
        end
      end
      default: state_d = gpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gpq_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      prev_q    <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (lane_step) begin
        prev_q <= act;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      frame_q <= gpq_pkg::frame_t'(s_axis_tdata[gpq_pkg::FRAME_W-1:0]);
    end
    if (lane_step) begin
      held_q  <= act;
      press_q <= act & ~prev_q;
      rel_q   <= prev_q & ~act;
      first_q <= first_d;
    end
    fire_q <= fire_d;
    if (load_out) begin
      result_q.held_bits     <= held_q;
      result_q.press_edges   <= press_q;
      result_q.release_edges <= rel_q;
      result_q.first_active  <= first_q;
      result_q.repeat_fire   <= fire_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = gpq_pkg::OUT_TDATA_W'(result_q);

  // Checks
  a_rem_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> state_q == gpq_pkg::ST_DIV)
    else $error("remainder finished outside the divide step");

  a_edges_vs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((result_q.press_edges & ~result_q.held_bits) == '0) &&
                      ((result_q.release_edges & result_q.held_bits) == '0))
    else $error("edge flags disagree with held flags");

  a_first_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((result_q.held_bits == '0) ==
                       (result_q.first_active == gpq_pkg::FIRST_NONE)))
    else $error("first_active disagrees with held flags");

  a_step_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> lane_step)
    else $error("accepted frame not qualified in the next cycle");

endmodule

[tb/tb_gamepad_input_qualifier_top.sv]
// Self-checking testbench for gamepad_input_qualifier_top: qualification, edges, hold and repeat.
`timescale 1ns / 1ps

module tb_gamepad_input_qualifier_top;
  import gpq_pkg::*;

  localparam int unsigned HALF_PERIOD      = 5;
  localparam int unsigned HOLD_W           = 16;
  localparam int unsigned HOLD_TOP         = (1 << HOLD_W) - 1;
  localparam int unsigned SETTLE_CYCLES    = HOLD_W + 12;
  localparam int unsigned CYCLE_LIMIT      = 4_000_000;
  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned PHASE_FRAMES     = 180;
  localparam int unsigned QUIET_PHASE      = 2;
  localparam int unsigned LONG_HOLD_FRAMES = 120;

  // index past the register list; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  // query index beyond every counter
  localparam logic [QIDX_W-1:0]    QIDX_OUTSIDE  = 5'd31;

  localparam logic [QIDX_W-1:0] QIDX_L_UP   = QIDX_W'(IDX_L_UP);
  localparam logic [QIDX_W-1:0] QIDX_L_TRIG = QIDX_W'(IDX_L_TRIG);
  localparam logic [QIDX_W-1:0] QIDX_R_TRIG = QIDX_W'(IDX_R_TRIG);

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  gamepad_input_qualifier_top #(
    .HOLD_WIDTH(HOLD_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // mirror of the block's registers and state
  int unsigned        fs_x;
  int unsigned        fs_y;
  logic [PULL_W-1:0]  trig_thr;
  logic [NUM_ALL-1:0] prev_act;
  logic [HOLD_W-1:0]  hold_cnt [NUM_HOLD];

  result_t     qualified_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned stall_left   = 0;
  bit          idle_enable  = 1'b1;

  // slowly changing pad used by the random part
  logic [NUM_BUTTONS-1:0] pad_buttons;
  logic [AXIS_W-1:0]      pad_axis [4];
  logic [PULL_W-1:0]      pad_pull [2];

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded the cycle limit", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic bit axis_over(input logic [AXIS_W-1:0] raw, input int unsigned fs);
    int twice;
    twice = 2 * int'($signed(raw));
    return twice > int'(fs);
  endfunction

  function automatic bit axis_under(input logic [AXIS_W-1:0] raw, input int unsigned fs);
    int twice;
    twice = 2 * int'($signed(raw));
    return twice < -int'(fs);
  endfunction

  function automatic frame_t make_frame(input logic [NUM_BUTTONS-1:0] buttons,
                                        input int lx, input int ly, input int rx, input int ry,
                                        input logic [PULL_W-1:0] lp, input logic [PULL_W-1:0] rp,
                                        input logic [QIDX_W-1:0] q,
                                        input logic [QTIME_W-1:0] dly,
                                        input logic [QTIME_W-1:0] per);
    frame_t f;
    f.button_bits  = buttons;
    f.left_x       = 16'(lx);
    f.left_y       = 16'(ly);
    f.right_x      = 16'(rx);
    f.right_y      = 16'(ry);
    f.left_pull    = lp;
    f.right_pull   = rp;
    f.query_index  = q;
    f.query_delay  = dly;
    f.query_period = per;
    return f;
  endfunction

  // Qualify one frame against the mirrored state and advance it.
  task automatic qualify_frame(input frame_t f, output result_t r);
    logic [NUM_ALL-1:0] act;
    int unsigned        h;
    int unsigned        dly;
    int unsigned        per;
    int                 i;
    act = '0;
    act[NUM_BUTTONS-1:0] = f.button_bits;
    act[IDX_L_UP]    = axis_over(f.left_y, fs_y);
    act[IDX_L_DOWN]  = axis_under(f.left_y, fs_y);
    act[IDX_L_RIGHT] = axis_over(f.left_x, fs_x);
    act[IDX_L_LEFT]  = axis_under(f.left_x, fs_x);
    act[IDX_R_UP]    = axis_over(f.right_y, fs_y);
    act[IDX_R_DOWN]  = axis_under(f.right_y, fs_y);
    act[IDX_R_RIGHT] = axis_over(f.right_x, fs_x);
    act[IDX_R_LEFT]  = axis_under(f.right_x, fs_x);
    act[IDX_L_TRIG]  = f.left_pull > trig_thr;
    act[IDX_R_TRIG]  = f.right_pull > trig_thr;

    r.held_bits     = act;
    r.press_edges   = act & ~prev_act;
    r.release_edges = prev_act & ~act;
    prev_act = act;

    for (i = 0; i < NUM_HOLD; i++) begin
      if (!act[i]) hold_cnt[i] = '0;
      else if (hold_cnt[i] != HOLD_TOP[HOLD_W-1:0]) hold_cnt[i] = hold_cnt[i] + 1'b1;
    end

    r.first_active = FIRST_NONE;
    for (i = NUM_ALL - 1; i >= 0; i--) begin
      if (act[i]) r.first_active = FIRST_W'(i);
    end

    // answer uses the counters as updated by this frame
    r.repeat_fire = 1'b0;
    if (f.query_index < NUM_HOLD) begin
      h   = 32'(hold_cnt[f.query_index]);
      dly = 32'(f.query_delay);
      per = 32'(f.query_period);
      if (h > dly) r.repeat_fire = (per != 0) && ((h - dly) % per == 0);
      else         r.repeat_fire = (h == 1);
    end
  endtask

  task automatic send_frame(input frame_t f);
    result_t     r;
    int unsigned gap;
    s_axis_tdata  <= {{(IN_TDATA_W - FRAME_W){1'b0}}, f};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    qualify_frame(f, r);
    qualified_q.push_back(r);
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (qualified_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FULL_SCALE_X:   fs_x = 32'(data);
      CFG_FULL_SCALE_Y:   fs_y = 32'(data);
      CFG_TRIG_THRESHOLD: trig_thr = data[PULL_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_cnt++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] data);
    result_t got;
    result_t want;
    got = data[RESULT_W-1:0];
    if (qualified_q.size() == 0) begin
      mismatch_cnt++;
      $display("%0t: result with nothing expected: expected none, actual %h", $time, data);
      return;
    end
    want = qualified_q.pop_front();
    if (got.held_bits !== want.held_bits)
      note_mismatch("held_bits", 32'(want.held_bits), 32'(got.held_bits));
    if (got.press_edges !== want.press_edges)
      note_mismatch("press_edges", 32'(want.press_edges), 32'(got.press_edges));
    if (got.release_edges !== want.release_edges)
      note_mismatch("release_edges", 32'(want.release_edges), 32'(got.release_edges));
    if (got.first_active !== want.first_active)
      note_mismatch("first_active", 32'(want.first_active), 32'(got.first_active));
    if (got.repeat_fire !== want.repeat_fire)
      note_mismatch("repeat_fire", 32'(want.repeat_fire), 32'(got.repeat_fire));
    if (data[OUT_TDATA_W-1:RESULT_W] !== '0)
      note_mismatch("tdata padding", '0, 32'(data[OUT_TDATA_W-1:RESULT_W]));
  endtask

  // receiver: check each transfer, then pick the next ready value
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = idle_len();
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [AXIS_W-1:0] pick_axis(input int unsigned fs);
    int v;
    case ($urandom_range(0, 4))
      0:       v = int'($urandom_range(0, 65535)) - 32768;
      1:       v = int'(fs / 2) + int'($urandom_range(0, 2)) - 1;
      2:       v = -(int'(fs / 2) + int'($urandom_range(0, 2)));
      3:       v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = 0;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[AXIS_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_scale();
    case ($urandom_range(0, 9))
      0:       return 16'd1;
      1:       return 16'd32768;
      2:       return FULL_SCALE_RST;
      3:       return 16'd0;
      4:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1, 32768));
    endcase
  endfunction

  // Mostly a pad that changes a little each frame so counters build up; some noise.
  task automatic next_frame(output frame_t f);
    int unsigned r;
    int unsigned j;
    int unsigned k;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      f.button_bits  = NUM_BUTTONS'($urandom);
      f.left_x       = AXIS_W'($urandom);
      f.left_y       = AXIS_W'($urandom);
      f.right_x      = AXIS_W'($urandom);
      f.right_y      = AXIS_W'($urandom);
      f.left_pull    = PULL_W'($urandom);
      f.right_pull   = PULL_W'($urandom);
      f.query_index  = QIDX_W'($urandom_range(0, NUM_ALL - 1));
      f.query_delay  = QTIME_W'($urandom);
      f.query_period = QTIME_W'($urandom);
      return;
    end
    if ($urandom_range(0, 3) == 0) pad_buttons = pad_buttons ^ (16'h1 << $urandom_range(0, 15));
    if ($urandom_range(0, 19) == 0) pad_buttons = NUM_BUTTONS'($urandom);
    for (k = 0; k < 4; k++) begin
      if ($urandom_range(0, 7) == 0) pad_axis[k] = pick_axis(k[0] ? fs_y : fs_x);
    end
    for (k = 0; k < 2; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        v = int'(trig_thr) + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        pad_pull[k] = $urandom_range(0, 1) ? PULL_W'($urandom) : PULL_W'(v);
      end
    end
    f.button_bits = pad_buttons;
    f.left_x      = pad_axis[0];
    f.left_y      = pad_axis[1];
    f.right_x     = pad_axis[2];
    f.right_y     = pad_axis[3];
    f.left_pull   = pad_pull[0];
    f.right_pull  = pad_pull[1];

    r = $urandom_range(0, 9);
    if (r < 5 && pad_buttons != '0) begin
      j = $urandom_range(0, NUM_BUTTONS - 1);
      while (!pad_buttons[j]) j = (j + 1) % NUM_BUTTONS;
      f.query_index = QIDX_W'(j);
    end else if (r < 8) begin
      f.query_index = QIDX_W'($urandom_range(NUM_BUTTONS, NUM_HOLD - 1));
    end else begin
      f.query_index = QIDX_W'($urandom_range(0, NUM_ALL - 1));
    end

    r = $urandom_range(0, 9);
    if (r < 6)      f.query_delay = QTIME_W'($urandom_range(0, 4));
    else if (r < 9) f.query_delay = QTIME_W'($urandom_range(5, 40));
    else            f.query_delay = QTIME_W'($urandom);

    r = $urandom_range(0, 9);
    if (r < 1)      f.query_period = '0;
    else if (r < 7) f.query_period = QTIME_W'($urandom_range(1, 6));
    else if (r < 9) f.query_period = QTIME_W'($urandom_range(7, 40));
    else            f.query_period = QTIME_W'($urandom);
  endtask

  // register defaults, extremes of every field, edges and lowest index
  task automatic test_reset_defaults();
    send_frame(make_frame(16'h0000, 0, 0, 0, 0, 8'd0, 8'd0, 5'd0, 16'd0, 16'd0));
    send_frame(make_frame(16'hFFFF, 32767, -32768, -32768, 32767, 8'd255, 8'd255,
                          5'd0, 16'd0, 16'd1));
    // just past and just short of half scale, triggers either side of the threshold
    send_frame(make_frame(16'h8000, 16384, -16384, -16383, 16383, 8'd128, 8'd127,
                          QIDX_L_TRIG, 16'd0, 16'd1));
    send_frame(make_frame(16'h0000, 16383, 0, 0, -16384, 8'd127, 8'd128,
                          QIDX_R_TRIG, 16'd0, 16'd1));
    send_frame(make_frame(16'h0000, 0, 0, 0, 0, 8'd0, 8'd0, QIDX_OUTSIDE, 16'd0, 16'd1));
  endtask

  task automatic test_registers();
    wait_idle();
    write_reg(CFG_FULL_SCALE_X, 16'd1);
    write_reg(CFG_FULL_SCALE_Y, 16'd32768);
    write_reg(CFG_TRIG_THRESHOLD, 16'd0);
    send_frame(make_frame(16'h0000, 1, 16384, -1, -16385, 8'd0, 8'd1, 5'd0, 16'd0, 16'd1));
    send_frame(make_frame(16'h0000, 0, 16385, 0, -16384, 8'd1, 8'd0, 5'd0, 16'd0, 16'd1));
    wait_idle();
    // zero full scale: any nonzero axis fires; threshold at max never fires
    write_reg(CFG_FULL_SCALE_X, 16'd0);
    write_reg(CFG_FULL_SCALE_Y, 16'd0);
    write_reg(CFG_TRIG_THRESHOLD, 16'd255);
    send_frame(make_frame(16'h0000, 1, -1, 0, 0, 8'd255, 8'd255, 5'd0, 16'd0, 16'd1));
    send_frame(make_frame(16'h0000, 0, 0, -1, 1, 8'd0, 8'd0, 5'd0, 16'd0, 16'd1));
    wait_idle();
    write_reg(CFG_IDX_SPARE, 16'd5);
    send_frame(make_frame(16'h0000, 1, 0, 0, 0, 8'd0, 8'd0, 5'd0, 16'd0, 16'd1));
    wait_idle();
    // only the low byte is the threshold
    write_reg(CFG_TRIG_THRESHOLD, 16'hAB80);
    send_frame(make_frame(16'h0000, 0, 0, 0, 0, 8'h81, 8'h80, 5'd0, 16'd0, 16'd1));
    wait_idle();
    write_reg(CFG_FULL_SCALE_X, FULL_SCALE_RST);
    write_reg(CFG_FULL_SCALE_Y, FULL_SCALE_RST);
    write_reg(CFG_TRIG_THRESHOLD, {8'h00, TRIG_THR_RST});
  endtask

  task automatic test_repeat_timing();
    int unsigned k;
    // delay 2, period 3: fires on press and when the counter reaches 5
    for (k = 0; k < 6; k++)
      send_frame(make_frame(16'h0008, 0, 0, 0, 0, 8'd0, 8'd0, 5'd3, 16'd2, 16'd3));
    // zero period past the delay never fires
    send_frame(make_frame(16'h0008, 0, 0, 0, 0, 8'd0, 8'd0, 5'd3, 16'd0, 16'd0));
    send_frame(make_frame(16'h0000, 0, 0, 0, 0, 8'd0, 8'd0, 5'd3, 16'd0, 16'd1));
    // press moment still fires with zero period
    send_frame(make_frame(16'h0008, 0, 0, 0, 0, 8'd0, 8'd0, 5'd3, 16'd4, 16'd0));
    send_frame(make_frame(16'h0000, 0, 32767, 0, 0, 8'd255, 8'd0, QIDX_L_UP, 16'd1, 16'd1));
    send_frame(make_frame(16'h0000, 0, 32767, 0, 0, 8'd255, 8'd0, QIDX_L_UP, 16'd1, 16'd1));
    // trigger held, but triggers never repeat
    send_frame(make_frame(16'h0000, 0, 32767, 0, 0, 8'd255, 8'd0, QIDX_L_TRIG, 16'd0, 16'd1));
  endtask

  // hold one button and one stick direction for a long run, then query far along
  task automatic test_long_hold();
    int unsigned k;
    wait_idle();
    idle_enable = 1'b0;
    send_frame(make_frame(16'h0000, 0, 0, 0, 0, 8'd0, 8'd0, QIDX_L_TRIG, 16'd0, 16'd1));
    for (k = 0; k < LONG_HOLD_FRAMES; k++)
      send_frame(make_frame(16'h0001, 0, 32767, 0, 0, 8'd0, 8'd0, QIDX_L_TRIG,
                            16'd0, 16'd1));
    send_frame(make_frame(16'h0001, 0, 32767, 0, 0, 8'd0, 8'd0, 5'd0, 16'd100, 16'd7));
    send_frame(make_frame(16'h0001, 0, 32767, 0, 0, 8'd0, 8'd0, QIDX_L_UP, 16'd0, 16'd65535));
    send_frame(make_frame(16'h0001, 0, 32767, 0, 0, 8'd0, 8'd0, 5'd0, 16'd0, 16'd3));
    send_frame(make_frame(16'h0001, 0, 32767, 0, 0, 8'd0, 8'd0, QIDX_L_UP, 16'd65535, 16'd1));
    send_frame(make_frame(16'h0001, 0, 32767, 0, 0, 8'd0, 8'd0, 5'd0, 16'd123, 16'd2));
    wait_idle();
    idle_enable = 1'b1;
  endtask

  task automatic test_random_play();
    frame_t      f;
    int unsigned phase;
    int unsigned n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      // every phase starts from an empty pipe, so the sender waits for all results here
      wait_idle();
      case (phase)
        0: begin
          write_reg(CFG_FULL_SCALE_X, FULL_SCALE_RST);
          write_reg(CFG_FULL_SCALE_Y, FULL_SCALE_RST);
          write_reg(CFG_TRIG_THRESHOLD, {8'h00, TRIG_THR_RST});
        end
        1: begin
          write_reg(CFG_FULL_SCALE_X, 16'd1);
          write_reg(CFG_FULL_SCALE_Y, 16'd1);
          write_reg(CFG_TRIG_THRESHOLD, 16'd0);
        end
        RANDOM_PHASES - 1: begin
          write_reg(CFG_FULL_SCALE_X, 16'd32768);
          write_reg(CFG_FULL_SCALE_Y, 16'd32768);
          write_reg(CFG_TRIG_THRESHOLD, {8'(($urandom)), 8'd255});
        end
        default: begin
          write_reg(CFG_FULL_SCALE_X, pick_scale());
          write_reg(CFG_FULL_SCALE_Y, pick_scale());
          write_reg(CFG_TRIG_THRESHOLD, CFG_DATA_W'($urandom));
        end
      endcase
      if ($urandom_range(0, 1) == 0) write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
      idle_enable = (phase != QUIET_PHASE);
      for (n = 0; n < PHASE_FRAMES; n++) begin
        next_frame(f);
        send_frame(f);
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    fs_x        = FULL_SCALE_RST;
    fs_y        = FULL_SCALE_RST;
    trig_thr    = TRIG_THR_RST;
    prev_act    = '0;
    pad_buttons = '0;
    foreach (hold_cnt[i]) hold_cnt[i] = '0;
    foreach (pad_axis[i]) pad_axis[i] = '0;
    foreach (pad_pull[i]) pad_pull[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_registers();
    test_repeat_timing();
    test_long_hold();
    test_random_play();
    wait_idle();

    if (mismatch_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
